// ----- hdl/mer_pkg.sv -----
`default_nettype none
package mer_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int CENTRE_W        = 11;
    localparam int PIX_W           = 13;

    // multiplier operand selects
    localparam logic [3:0] MUL_NONE    = 4'd0;
    localparam logic [3:0] MUL_RX_RX   = 4'd1;
    localparam logic [3:0] MUL_RY_RY   = 4'd2;
    localparam logic [3:0] MUL_RX2_Y   = 4'd3;
    localparam logic [3:0] MUL_RY2_X   = 4'd4;
    localparam logic [3:0] MUL_T_T     = 4'd5;
    localparam logic [3:0] MUL_YM1_SQ  = 4'd6;
    localparam logic [3:0] MUL_RY2_TMP = 4'd7;
    localparam logic [3:0] MUL_RX2_TMP = 4'd8;
    localparam logic [3:0] MUL_RX2_RY2 = 4'd9;

    // datapath register actions
    localparam logic [3:0] ACT_NONE     = 4'd0;
    localparam logic [3:0] ACT_LOAD     = 4'd1;
    localparam logic [3:0] ACT_LD_RX2   = 4'd2;
    localparam logic [3:0] ACT_LD_RY2   = 4'd3;
    localparam logic [3:0] ACT_INIT_D   = 4'd4;
    localparam logic [3:0] ACT_LD_TMP   = 4'd5;
    localparam logic [3:0] ACT_D_SET    = 4'd6;
    localparam logic [3:0] ACT_D_ADD4   = 4'd7;
    localparam logic [3:0] ACT_D_SUB4   = 4'd8;
    localparam logic [3:0] ACT_ADV_MOVE = 4'd9;
    localparam logic [3:0] ACT_ADV_UPD  = 4'd10;
    localparam logic [3:0] ACT_FINISH   = 4'd11;

    localparam logic [1:0] QUAD_PX_PY = 2'd0;
    localparam logic [1:0] QUAD_NX_PY = 2'd1;
    localparam logic [1:0] QUAD_NX_NY = 2'd2;
    localparam logic [1:0] QUAD_PX_NY = 2'd3;

    typedef struct packed {
        logic [3:0] mul_sel;
        logic [3:0] act;
        logic       emit;
        logic       nact;
        logic [1:0] quad;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic region2;
        logic y_zero;
        logic prod_zero;
        logic tmp_lt_prod;
    } t_sts;

endpackage
`default_nettype wire

// ----- hdl/mer_dpath.sv -----
`default_nettype none
module mer_dpath #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire mer_pkg::t_cmd                    i_cmd,
    output mer_pkg::t_sts                         o_sts,
    input  wire logic [mer_pkg::CENTRE_W-1:0]     i_center_x,
    input  wire logic [mer_pkg::CENTRE_W-1:0]     i_center_y,
    input  wire logic [RADIUS_BITS-1:0]           i_radius_x,
    input  wire logic [RADIUS_BITS-1:0]           i_radius_y,
    output logic                                  o_valid,
    output logic signed [mer_pkg::PIX_W-1:0]      o_pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]      o_pixel_y,
    output logic [1:0]                            o_quadrant,
    output logic                                  o_last,
    output logic                                  o_done_res,
    output logic                                  o_not_active
);

    localparam int R  = RADIUS_BITS;
    localparam int MW = 2 * R + 2;
    localparam int DW = 2 * MW;
    localparam int EW = ((R > mer_pkg::CENTRE_W) ? R : mer_pkg::CENTRE_W) + 2;

    logic [R-1:0]                   r_x, r_y, r_rx;
    logic [2*R-1:0]                 r_rx2, r_ry2;
    logic [mer_pkg::CENTRE_W-1:0]   r_cx, r_cy;
    logic [DW-1:0]                  r_d, r_tmp, r_prod;
    logic                           r_region2, r_active, r_mov;

    logic                           r_valid, r_last, r_done, r_nact;
    logic [mer_pkg::PIX_W-1:0]      r_px, r_py;
    logic [1:0]                     r_quad;

    logic [MW-1:0]                  mul_a, mul_b;
    logic [R-1:0]                   ym1_mag;
    logic [DW-1:0]                  rx2_e, ry2_e, upd_add, upd_sub;
    logic                           d_neg, d_pos, add_a, sub_b;
    logic [EW-1:0]                  cx_e, cy_e, x_e, y_e, px_sum, py_sum;
    logic                           x_plus, y_plus;

    assign ym1_mag = (r_y == '0) ? R'(1) : r_y - R'(1);
    assign rx2_e   = {{(DW-2*R){1'b0}}, r_rx2};
    assign ry2_e   = {{(DW-2*R){1'b0}}, r_ry2};
    assign d_neg   = r_d[DW-1];
    assign d_pos   = !d_neg && (r_d != '0);

    // operand select for the shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            mer_pkg::MUL_RX_RX: begin
                mul_a = {{(MW-R){1'b0}}, r_rx};
                mul_b = {{(MW-R){1'b0}}, r_rx};
            end
            mer_pkg::MUL_RY_RY: begin
                mul_a = {{(MW-R){1'b0}}, r_y};
                mul_b = {{(MW-R){1'b0}}, r_y};
            end
            mer_pkg::MUL_RX2_Y: begin
                mul_a = {2'b00, r_rx2};
                mul_b = {{(MW-R){1'b0}}, r_y};
            end
            mer_pkg::MUL_RY2_X: begin
                mul_a = {2'b00, r_ry2};
                mul_b = {{(MW-R){1'b0}}, r_x};
            end
            mer_pkg::MUL_T_T: begin
                mul_a = {{(MW-R-1){1'b0}}, r_x, 1'b1};
                mul_b = {{(MW-R-1){1'b0}}, r_x, 1'b1};
            end
            mer_pkg::MUL_YM1_SQ: begin
                mul_a = {{(MW-R){1'b0}}, ym1_mag};
                mul_b = {{(MW-R){1'b0}}, ym1_mag};
            end
            mer_pkg::MUL_RY2_TMP: begin
                mul_a = {2'b00, r_ry2};
                mul_b = r_tmp[MW-1:0];
            end
            mer_pkg::MUL_RX2_TMP: begin
                mul_a = {2'b00, r_rx2};
                mul_b = r_tmp[MW-1:0];
            end
            mer_pkg::MUL_RX2_RY2: begin
                mul_a = {2'b00, r_rx2};
                mul_b = {2'b00, r_ry2};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // region 1 always adds 8*ry2*x and subtracts 8*rx2*y on a diagonal move;
    // region 2 always subtracts 8*rx2*y and adds 8*ry2*x on a diagonal move
    assign add_a   = !r_region2 || r_mov;
    assign sub_b   = r_region2 || r_mov;
    assign upd_add = (add_a ? (r_tmp << 3) : '0) + ((r_region2 ? rx2_e : ry2_e) << 2);
    assign upd_sub = sub_b ? (r_prod << 3) : '0;

    always_ff @(posedge i_clk) begin
        r_prod <= {{MW{1'b0}}, mul_a} * {{MW{1'b0}}, mul_b};
        case (i_cmd.act)
            mer_pkg::ACT_LOAD: begin
                r_cx      <= i_center_x;
                r_cy      <= i_center_y;
                r_rx      <= i_radius_x;
                r_y       <= i_radius_y;
                r_x       <= '0;
                r_region2 <= 1'b0;
            end
            mer_pkg::ACT_LD_RX2:  r_rx2 <= r_prod[2*R-1:0];
            mer_pkg::ACT_LD_RY2:  r_ry2 <= r_prod[2*R-1:0];
            mer_pkg::ACT_INIT_D:  r_d   <= (ry2_e << 2) - (r_prod << 2) + rx2_e;
            mer_pkg::ACT_LD_TMP:  r_tmp <= r_prod;
            mer_pkg::ACT_D_SET:   r_d   <= r_prod;
            mer_pkg::ACT_D_ADD4:  r_d   <= r_d + (r_prod << 2);
            mer_pkg::ACT_D_SUB4: begin
                r_d       <= r_d - (r_prod << 2);
                r_region2 <= 1'b1;
            end
            mer_pkg::ACT_ADV_MOVE: begin
                if (!r_region2) begin
                    r_x   <= r_x + R'(1);
                    r_mov <= !d_neg;
                    if (!d_neg) begin
                        r_y <= r_y - R'(1);
                    end
                end else begin
                    r_y   <= r_y - R'(1);
                    r_mov <= !d_pos;
                    if (!d_pos) begin
                        r_x <= r_x + R'(1);
                    end
                end
            end
            mer_pkg::ACT_ADV_UPD: r_d <= r_d + upd_add - upd_sub;
            default: ;
        endcase
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.act == mer_pkg::ACT_LOAD) begin
            r_active <= 1'b1;
        end else if (i_cmd.act == mer_pkg::ACT_FINISH) begin
            r_active <= 1'b0;
        end
    end

    assign o_sts.active      = r_active;
    assign o_sts.region2     = r_region2;
    assign o_sts.y_zero      = (r_y == '0);
    assign o_sts.prod_zero   = (r_prod == '0);
    assign o_sts.tmp_lt_prod = (r_tmp < r_prod);

    // pixel formation
    assign x_plus = (i_cmd.quad == mer_pkg::QUAD_PX_PY) || (i_cmd.quad == mer_pkg::QUAD_PX_NY);
    assign y_plus = (i_cmd.quad == mer_pkg::QUAD_PX_PY) || (i_cmd.quad == mer_pkg::QUAD_NX_PY);
    assign cx_e   = {{(EW-mer_pkg::CENTRE_W){1'b0}}, r_cx};
    assign cy_e   = {{(EW-mer_pkg::CENTRE_W){1'b0}}, r_cy};
    assign x_e    = {{(EW-R){1'b0}}, r_x};
    assign y_e    = {{(EW-R){1'b0}}, r_y};
    assign px_sum = x_plus ? cx_e + x_e : cx_e - x_e;
    assign py_sum = y_plus ? cy_e + y_e : cy_e - y_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_nact  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            r_nact  <= i_cmd.emit && i_cmd.nact;
            r_last  <= i_cmd.emit && (i_cmd.nact || i_cmd.last);
        end
        if (i_cmd.nact) begin
            r_px   <= '0;
            r_py   <= '0;
            r_quad <= mer_pkg::QUAD_PX_PY;
            r_done <= 1'b0;
        end else begin
            r_px   <= px_sum[mer_pkg::PIX_W-1:0];
            r_py   <= py_sum[mer_pkg::PIX_W-1:0];
            r_quad <= i_cmd.quad;
            r_done <= (r_y == '0);
        end
    end

    assign o_valid      = r_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_quadrant   = r_quad;
    assign o_last       = r_last;
    assign o_done_res   = r_done;
    assign o_not_active = r_nact;

    a_nact_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nact |-> (r_valid && r_last))
        else $error("not-active flag outside a single-beat result");

    a_last_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last && !r_nact) |-> (r_quad == mer_pkg::QUAD_PX_NY))
        else $error("last beat of a step is not the fourth quadrant");

endmodule
`default_nettype wire

// ----- hdl/mer_ctrl.sv -----
`default_nettype none
module mer_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_op,
    output logic               o_busy,
    output mer_pkg::t_cmd      o_cmd,
    input  wire mer_pkg::t_sts i_sts
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_INIT1 = 5'd1;
    localparam logic [4:0] ST_INIT2 = 5'd2;
    localparam logic [4:0] ST_INIT3 = 5'd3;
    localparam logic [4:0] ST_INIT4 = 5'd4;
    localparam logic [4:0] ST_EMIT  = 5'd5;
    localparam logic [4:0] ST_ADV0  = 5'd6;
    localparam logic [4:0] ST_ADV1  = 5'd7;
    localparam logic [4:0] ST_ADV2  = 5'd8;
    localparam logic [4:0] ST_ADV3  = 5'd9;
    localparam logic [4:0] ST_ENT1  = 5'd10;
    localparam logic [4:0] ST_ENT2  = 5'd11;
    localparam logic [4:0] ST_ENT3  = 5'd12;
    localparam logic [4:0] ST_ENT4  = 5'd13;
    localparam logic [4:0] ST_ENT5  = 5'd14;
    localparam logic [4:0] ST_ENT6  = 5'd15;

    logic [4:0] r_state, n_state;
    logic [1:0] r_quad, n_quad;

    always_comb begin
        n_state       = r_state;
        n_quad        = r_quad;
        o_cmd         = '0;
        o_cmd.mul_sel = mer_pkg::MUL_NONE;
        o_cmd.act     = mer_pkg::ACT_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (!i_op) begin
                        o_cmd.act = mer_pkg::ACT_LOAD;
                        n_state   = ST_INIT1;
                    end else if (i_sts.active) begin
                        n_quad  = mer_pkg::QUAD_PX_PY;
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.emit = 1'b1;
                        o_cmd.nact = 1'b1;
                    end
                end
            end
            ST_INIT1: begin
                o_cmd.mul_sel = mer_pkg::MUL_RX_RX;
                n_state       = ST_INIT2;
            end
            ST_INIT2: begin
                o_cmd.act     = mer_pkg::ACT_LD_RX2;
                o_cmd.mul_sel = mer_pkg::MUL_RY_RY;
                n_state       = ST_INIT3;
            end
            ST_INIT3: begin
                o_cmd.act     = mer_pkg::ACT_LD_RY2;
                o_cmd.mul_sel = mer_pkg::MUL_RX2_Y;
                n_state       = ST_INIT4;
            end
            ST_INIT4: begin
                // at x = 0 the switch test reduces to rx2*ry == 0
                o_cmd.act = mer_pkg::ACT_INIT_D;
                n_state   = i_sts.prod_zero ? ST_ENT1 : ST_IDLE;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.quad = r_quad;
                o_cmd.last = (r_quad == mer_pkg::QUAD_PX_NY);
                n_quad     = r_quad + 2'd1;
                if (r_quad == mer_pkg::QUAD_PX_NY) begin
                    if (i_sts.y_zero) begin
                        o_cmd.act = mer_pkg::ACT_FINISH;
                        n_state   = ST_IDLE;
                    end else begin
                        n_state = ST_ADV0;
                    end
                end
            end
            ST_ADV0: begin
                o_cmd.act = mer_pkg::ACT_ADV_MOVE;
                n_state   = ST_ADV1;
            end
            ST_ADV1: begin
                o_cmd.mul_sel = mer_pkg::MUL_RY2_X;
                n_state       = ST_ADV2;
            end
            ST_ADV2: begin
                o_cmd.act     = mer_pkg::ACT_LD_TMP;
                o_cmd.mul_sel = mer_pkg::MUL_RX2_Y;
                n_state       = ST_ADV3;
            end
            ST_ADV3: begin
                o_cmd.act = mer_pkg::ACT_ADV_UPD;
                n_state   = (!i_sts.region2 && !i_sts.tmp_lt_prod) ? ST_ENT1 : ST_IDLE;
            end
            ST_ENT1: begin
                o_cmd.mul_sel = mer_pkg::MUL_T_T;
                n_state       = ST_ENT2;
            end
            ST_ENT2: begin
                o_cmd.act     = mer_pkg::ACT_LD_TMP;
                o_cmd.mul_sel = mer_pkg::MUL_YM1_SQ;
                n_state       = ST_ENT3;
            end
            ST_ENT3: begin
                // multiplier reads (2x+1)^2 while tmp takes (y-1)^2
                o_cmd.act     = mer_pkg::ACT_LD_TMP;
                o_cmd.mul_sel = mer_pkg::MUL_RY2_TMP;
                n_state       = ST_ENT4;
            end
            ST_ENT4: begin
                o_cmd.act     = mer_pkg::ACT_D_SET;
                o_cmd.mul_sel = mer_pkg::MUL_RX2_TMP;
                n_state       = ST_ENT5;
            end
            ST_ENT5: begin
                o_cmd.act     = mer_pkg::ACT_D_ADD4;
                o_cmd.mul_sel = mer_pkg::MUL_RX2_RY2;
                n_state       = ST_ENT6;
            end
            ST_ENT6: begin
                o_cmd.act = mer_pkg::ACT_D_SUB4;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_quad  <= mer_pkg::QUAD_PX_PY;
        end else begin
            r_state <= n_state;
            r_quad  <= n_quad;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_op) |=> (r_state == ST_INIT1))
        else $error("start beat did not begin setup");

    a_emit_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && $past(r_state) != ST_EMIT) |-> (r_quad == mer_pkg::QUAD_PX_PY))
        else $error("emission did not begin at the first quadrant");

    a_emit_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> i_sts.active)
        else $error("emitting with no ellipse in progress");

endmodule
`default_nettype wire

// ----- hdl/midpoint_ellipse_rasterizer_core.sv -----
// Start beat: setup runs INIT1 to INIT4, then ENT1 to ENT6 when the ellipse begins in region 2.
// Step beat: four result beats on consecutive cycles, registered from the EMIT state; busy
// through EMIT and ADV0 to ADV3, then ENT1 to ENT6 when the step crosses into region 2, EMIT only on the final step.
// Step with no ellipse: one result beat the next cycle, busy stays low.
// The shared multiplier, one product per cycle, sets the advance length.
// Synchronous active-low reset clears the sequencer, result strobe and active flag.
`default_nettype none
module midpoint_ellipse_rasterizer_core #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_op,
    input  wire logic [mer_pkg::CENTRE_W-1:0] i_center_x,
    input  wire logic [mer_pkg::CENTRE_W-1:0] i_center_y,
    input  wire logic [RADIUS_BITS-1:0]       i_radius_x,
    input  wire logic [RADIUS_BITS-1:0]       i_radius_y,
    output logic                              o_valid,
    output logic signed [mer_pkg::PIX_W-1:0]  o_pixel_x,
    output logic signed [mer_pkg::PIX_W-1:0]  o_pixel_y,
    output logic [1:0]                        o_quadrant,
    output logic                              o_last,
    output logic                              o_done_res,
    output logic                              o_not_active
);

    mer_pkg::t_cmd cmd;
    mer_pkg::t_sts sts;

    mer_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    mer_dpath #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_center_x   (i_center_x),
        .i_center_y   (i_center_y),
        .i_radius_x   (i_radius_x),
        .i_radius_y   (i_radius_y),
        .o_valid      (o_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_quadrant   (o_quadrant),
        .o_last       (o_last),
        .o_done_res   (o_done_res),
        .o_not_active (o_not_active)
    );

endmodule
`default_nettype wire

// ----- dv/midpoint_ellipse_rasterizer_core_test.sv -----
`default_nettype none
module midpoint_ellipse_rasterizer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RB       = mer_pkg::RADIUS_BITS_DEF;
    localparam int CENTRE_W = mer_pkg::CENTRE_W;
    localparam int PIX_W    = mer_pkg::PIX_W;
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;
    localparam int RANDOM_ITEMS = 450;

    typedef struct {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [1:0]       quad;
        logic             last;
        logic             done;
        logic             nact;
    } t_pixel_beat;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                start      = 1'b0;
    logic                i_op       = OP_STEP;
    logic [CENTRE_W-1:0] i_center_x = '0;
    logic [CENTRE_W-1:0] i_center_y = '0;
    logic [RB-1:0]       i_radius_x = '0;
    logic [RB-1:0]       i_radius_y = '0;
    wire logic                    busy;
    wire logic                    o_valid;
    wire logic signed [PIX_W-1:0] o_pixel_x;
    wire logic signed [PIX_W-1:0] o_pixel_y;
    wire logic [1:0]              o_quadrant;
    wire logic                    o_last;
    wire logic                    o_done_res;
    wire logic                    o_not_active;

    midpoint_ellipse_rasterizer_core #(
        .RADIUS_BITS(RB)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius_x  (i_radius_x),
        .i_radius_y  (i_radius_y),
        .o_valid     (o_valid),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_quadrant  (o_quadrant),
        .o_last      (o_last),
        .o_done_res  (o_done_res),
        .o_not_active(o_not_active)
    );

    t_pixel_beat expected_pixels[$];
    int          error_count = 0;
    int          accepted_items = 0;

    // ellipse tracer state
    logic [31:0]         trc_ox, trc_oy;
    logic [63:0]         trc_dec, trc_rx2, trc_ry2;
    logic [CENTRE_W-1:0] trc_cx, trc_cy;
    logic                trc_region2 = 1'b0;
    logic                trc_active  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    task automatic enter_region_two();
        logic [63:0] t, ym1;
        t   = {32'b0, trc_ox} * 64'd2 + 64'd1;
        ym1 = {32'b0, trc_oy} - 64'd1;
        trc_dec = trc_ry2 * t * t + 64'd4 * trc_rx2 * ym1 * ym1
                - 64'd4 * trc_rx2 * trc_ry2;
        trc_region2 = 1'b1;
    endtask

    task automatic check_region_switch();
        if (!(trc_ry2 * {32'b0, trc_ox} < trc_rx2 * {32'b0, trc_oy}))
            enter_region_two();
    endtask

    task automatic advance_point();
        logic [63:0] x, y;
        if (!trc_region2) begin
            trc_ox++;
            x = {32'b0, trc_ox};
            if (trc_dec[63]) begin
                trc_dec = trc_dec + 64'd8 * trc_ry2 * x + 64'd4 * trc_ry2;
            end else begin
                trc_oy--;
                y = {32'b0, trc_oy};
                trc_dec = trc_dec + 64'd8 * trc_ry2 * x - 64'd8 * trc_rx2 * y
                        + 64'd4 * trc_ry2;
            end
            check_region_switch();
        end else begin
            trc_oy--;
            y = {32'b0, trc_oy};
            if (!trc_dec[63] && trc_dec != 64'd0) begin
                trc_dec = trc_dec + 64'd4 * trc_rx2 - 64'd8 * trc_rx2 * y;
            end else begin
                trc_ox++;
                x = {32'b0, trc_ox};
                trc_dec = trc_dec + 64'd8 * trc_ry2 * x - 64'd8 * trc_rx2 * y
                        + 64'd4 * trc_rx2;
            end
        end
    endtask

    task automatic trace_ellipse_item(input logic op, input logic [CENTRE_W-1:0] cx,
                                      input logic [CENTRE_W-1:0] cy,
                                      input logic [RB-1:0] rx, input logic [RB-1:0] ry);
        t_pixel_beat b;
        logic [31:0] px, py;
        logic        fin;
        if (op == OP_START) begin
            trc_cx  = cx;
            trc_cy  = cy;
            trc_rx2 = {{(64-RB){1'b0}}, rx} * {{(64-RB){1'b0}}, rx};
            trc_ry2 = {{(64-RB){1'b0}}, ry} * {{(64-RB){1'b0}}, ry};
            trc_ox  = '0;
            trc_oy  = {{(32-RB){1'b0}}, ry};
            trc_dec = 64'd4 * trc_ry2 - 64'd4 * trc_rx2 * {{(64-RB){1'b0}}, ry} + trc_rx2;
            trc_region2 = 1'b0;
            trc_active  = 1'b1;
            check_region_switch();
        end else if (!trc_active) begin
            b.px = '0; b.py = '0; b.quad = mer_pkg::QUAD_PX_PY;
            b.last = 1'b1; b.done = 1'b0; b.nact = 1'b1;
            expected_pixels.push_back(b);
        end else begin
            fin = (trc_oy == 32'd0);
            for (int k = 0; k < 4; k++) begin
                case (k)
                    0:       b.quad = mer_pkg::QUAD_PX_PY;
                    1:       b.quad = mer_pkg::QUAD_NX_PY;
                    2:       b.quad = mer_pkg::QUAD_NX_NY;
                    default: b.quad = mer_pkg::QUAD_PX_NY;
                endcase
                px = (b.quad == mer_pkg::QUAD_PX_PY || b.quad == mer_pkg::QUAD_PX_NY) ?
                     {21'b0, trc_cx} + trc_ox : {21'b0, trc_cx} - trc_ox;
                py = (b.quad == mer_pkg::QUAD_PX_PY || b.quad == mer_pkg::QUAD_NX_PY) ?
                     {21'b0, trc_cy} + trc_oy : {21'b0, trc_cy} - trc_oy;
                b.px   = px[PIX_W-1:0];
                b.py   = py[PIX_W-1:0];
                b.last = (b.quad == mer_pkg::QUAD_PX_NY);
                b.done = fin;
                b.nact = 1'b0;
                expected_pixels.push_back(b);
            end
            if (fin)
                trc_active = 1'b0;
            else
                advance_point();
        end
    endtask

    // Present one beat after a random gap; start stays high when the gap is zero.
    task automatic send_beat(input logic op, input logic [CENTRE_W-1:0] cx,
                             input logic [CENTRE_W-1:0] cy,
                             input logic [RB-1:0] rx, input logic [RB-1:0] ry);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= op;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius_x <= rx;
        i_radius_y <= ry;
        do @(posedge i_clk); while (busy !== 1'b0);
        accepted_items++;
        trace_ellipse_item(op, cx, cy, rx, ry);
    endtask

    task automatic start_ellipse(input logic [CENTRE_W-1:0] cx, input logic [CENTRE_W-1:0] cy,
                                 input logic [RB-1:0] rx, input logic [RB-1:0] ry);
        send_beat(OP_START, cx, cy, rx, ry);
    endtask

    // Unused fields carry random noise on a step.
    task automatic step_beat();
        send_beat(OP_STEP, CENTRE_W'($urandom), CENTRE_W'($urandom),
                  RB'($urandom), RB'($urandom));
    endtask

    task automatic draw_steps(input int max_steps);
        for (int n = 0; n < max_steps && trc_active; n++)
            step_beat();
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_pixel_beat want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected beat", {3'b0, o_pixel_x}, 16'h0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x !== want.px)
                    report_mismatch("pixel_x", {3'b0, o_pixel_x}, {3'b0, want.px});
                if (o_pixel_y !== want.py)
                    report_mismatch("pixel_y", {3'b0, o_pixel_y}, {3'b0, want.py});
                if (o_quadrant !== want.quad)
                    report_mismatch("quadrant", {14'b0, o_quadrant}, {14'b0, want.quad});
                if (o_last !== want.last)
                    report_mismatch("last", {15'b0, o_last}, {15'b0, want.last});
                if (o_done_res !== want.done)
                    report_mismatch("done_res", {15'b0, o_done_res}, {15'b0, want.done});
                if (o_not_active !== want.nact)
                    report_mismatch("not_active", {15'b0, o_not_active}, {15'b0, want.nact});
            end
        end
    end

    task automatic test_idle_steps();
        step_beat();
        step_beat();
    endtask

    task automatic test_degenerate_radii();
        // flat ellipse: centre four times, then nothing in progress
        start_ellipse(11'd100, 11'd200, 10'd5, 10'd0);
        step_beat();
        step_beat();
        // vertical run from region 2
        start_ellipse(11'd1024, 11'd1023, 10'd0, 10'd3);
        draw_steps(8);
        start_ellipse(11'd7, 11'd9, 10'd0, 10'd0);
        draw_steps(2);
    endtask

    task automatic test_offscreen_pixels();
        start_ellipse(11'd0, 11'd0, 10'd2, 10'd2);
        draw_steps(10);
        start_ellipse(11'd2047, 11'd2047, 10'd1023, 10'd1023);
        step_beat();
        step_beat();
    endtask

    task automatic test_restart_in_progress();
        start_ellipse(11'h555, 11'h2aa, 10'd1023, 10'd1);
        step_beat();
        step_beat();
        start_ellipse(11'h2aa, 11'h555, 10'd1, 10'd1023);
        step_beat();
        step_beat();
    endtask

    task automatic test_random_ellipses();
        int kind, cut;
        int stop_at;
        stop_at = accepted_items + RANDOM_ITEMS;
        while (accepted_items < stop_at) begin
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                step_beat();
            end else if (kind <= 2) begin
                // big ellipse, drawn only partway before the next start
                start_ellipse(CENTRE_W'($urandom), CENTRE_W'($urandom),
                              RB'($urandom), RB'($urandom));
                draw_steps($urandom_range(1, 12));
            end else begin
                start_ellipse(CENTRE_W'($urandom), CENTRE_W'($urandom),
                              RB'($urandom_range(0, 12)), RB'($urandom_range(0, 12)));
                cut = $urandom_range(0, 3);
                if (cut == 0) begin
                    draw_steps($urandom_range(0, 10));
                end else begin
                    draw_steps(100);
                    if (cut == 1)
                        step_beat();
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_steps();
        test_degenerate_radii();
        test_offscreen_pixels();
        test_restart_in_progress();
        test_random_ellipses();

        start <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
